// File: sv/frgcd_pkg.sv
package frgcd_pkg;

  // default operand width
  localparam int DATA_WIDTH_DEF = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUCLID,
    ST_REM,
    ST_CHECK,
    ST_QNUM,
    ST_QDEN,
    ST_FINISH
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/frgcd_div.sv
module frgcd_div #(
  parameter int DATA_WIDTH = frgcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output frgcd_pkg::div_stat_t         stat,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic signed [DATA_WIDTH-1:0] remainder
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic            busy;
  logic            done;
  logic [CW-1:0]   count;
  logic [DATA_WIDTH-1:0] rem_acc;
  logic [DATA_WIDTH-1:0] quo_sh;
  logic [DATA_WIDTH-1:0] dvs;
  logic            neg_q;
  logic            neg_r;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;

  // magnitudes fit in DATA_WIDTH unsigned bits, most negative value included
  assign mag_a = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;

  // one restoring step per cycle
  assign trial = {rem_acc, quo_sh[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DATA_WIDTH - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_acc <= '0;
      quo_sh  <= mag_a;
      dvs     <= mag_b;
      neg_q   <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      neg_r   <= dividend[DATA_WIDTH-1];
    end else if (busy) begin
      if (!diff[DATA_WIDTH]) begin
        rem_acc <= diff[DATA_WIDTH-1:0];
        quo_sh  <= {quo_sh[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_acc <= trial[DATA_WIDTH-1:0];
        quo_sh  <= {quo_sh[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  // truncating signs: quotient by sign xor, remainder follows dividend
  assign quotient  = neg_q ? (~quo_sh + 1'b1) : quo_sh;
  assign remainder = neg_r ? (~rem_acc + 1'b1) : rem_acc;

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: sv/fraction_reduce_gcd_unit.sv
// channel | signals                                              | direction
// --------+------------------------------------------------------+----------
// in      | in_valid, in_stall, numerator_in, denominator_in     | consumer
// out     | out_valid, out_stall, numerator_out, denominator_out,| producer
//         | common_divisor, error_flag                           |
//
// every euclid remainder and both final quotients run through the one radix-2 divider,
//   so a new item is taken only once the last one has been handed over
// in_stall is low only while the sequencer is idle
// a finished item waits in the output register; the next item is taken meanwhile
// rst is synchronous, active high, and clears sequencer and valid state
module fraction_reduce_gcd_unit #(
  parameter int DATA_WIDTH = frgcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] numerator_in,
  input  logic signed [DATA_WIDTH-1:0] denominator_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] numerator_out,
  output logic signed [DATA_WIDTH-1:0] denominator_out,
  output logic signed [DATA_WIDTH-1:0] common_divisor,
  output logic                         error_flag
);

  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] NEG_ONE = '1;

  frgcd_pkg::state_t state;
  frgcd_pkg::state_t state_next;

  // item registers
  logic signed [DATA_WIDTH-1:0] num;
  logic signed [DATA_WIDTH-1:0] den;
  logic signed [DATA_WIDTH-1:0] x;
  logic signed [DATA_WIDTH-1:0] y;
  logic signed [DATA_WIDTH-1:0] qn;
  logic signed [DATA_WIDTH-1:0] qd;
  logic                         err;

  // sequencer strobes
  logic load_in;
  logic step_xy;
  logic cap_qn;
  logic cap_qd;
  logic set_err;
  logic load_out;

  // shared divider
  logic                         div_start;
  logic signed [DATA_WIDTH-1:0] div_a;
  logic signed [DATA_WIDTH-1:0] div_b;
  logic signed [DATA_WIDTH-1:0] div_q;
  logic signed [DATA_WIDTH-1:0] div_r;
  frgcd_pkg::div_stat_t         div_stat;

  frgcd_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign in_stall = (state != frgcd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frgcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_in    = 1'b0;
    step_xy    = 1'b0;
    cap_qn     = 1'b0;
    cap_qd     = 1'b0;
    set_err    = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    div_a      = x;
    div_b      = y;
    case (state)
      frgcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          load_in    = 1'b1;
          state_next = frgcd_pkg::ST_EUCLID;
        end
      end
      frgcd_pkg::ST_EUCLID: begin
        // loop ends when the remainder reaches zero
        if (y == '0) begin
          state_next = frgcd_pkg::ST_CHECK;
        end else if (x == MIN_VAL && y == NEG_ONE) begin
          // remainder of most negative by minus one overflows
          set_err    = 1'b1;
          state_next = frgcd_pkg::ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = frgcd_pkg::ST_REM;
        end
      end
      frgcd_pkg::ST_REM: begin
        if (div_stat.done) begin
          step_xy    = 1'b1;
          state_next = frgcd_pkg::ST_EUCLID;
        end
      end
      frgcd_pkg::ST_CHECK: begin
        // zero divisor, or a quotient of most negative by minus one
        if (x == '0 || (x == NEG_ONE && (num == MIN_VAL || den == MIN_VAL))) begin
          set_err    = 1'b1;
          state_next = frgcd_pkg::ST_FINISH;
        end else begin
          div_start  = 1'b1;
          div_a      = num;
          div_b      = x;
          state_next = frgcd_pkg::ST_QNUM;
        end
      end
      frgcd_pkg::ST_QNUM: begin
        div_a = den;
        div_b = x;
        if (div_stat.done) begin
          cap_qn     = 1'b1;
          div_start  = 1'b1;
          state_next = frgcd_pkg::ST_QDEN;
        end
      end
      frgcd_pkg::ST_QDEN: begin
        if (div_stat.done) begin
          cap_qd     = 1'b1;
          state_next = frgcd_pkg::ST_FINISH;
        end
      end
      frgcd_pkg::ST_FINISH: begin
        // hand over once the output register is free or being taken
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = frgcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = frgcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      num <= numerator_in;
      den <= denominator_in;
      x   <= numerator_in;
      y   <= denominator_in;
      err <= 1'b0;
    end else begin
      if (step_xy) begin
        x <= y;
        y <= div_r;
      end
      if (set_err) begin
        err <= 1'b1;
      end
    end
    if (cap_qn) begin
      qn <= div_q;
    end
    if (cap_qd) begin
      qd <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (err) begin
        // error: inputs pass through, divisor reads zero
        numerator_out   <= num;
        denominator_out <= den;
        common_divisor  <= '0;
        error_flag      <= 1'b1;
      end else begin
        numerator_out   <= qn;
        denominator_out <= qd;
        common_divisor  <= x;
        error_flag      <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_flag) |-> (common_divisor == '0))
    else $error("error item with nonzero divisor");

  a_accept_euclid: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == frgcd_pkg::ST_EUCLID))
    else $error("accepted item did not start euclid loop");

endmodule

// File: tb/sv/fraction_reduce_gcd_unit_test.sv
`timescale 1ns / 1ps

module fraction_reduce_gcd_unit_test;

  localparam int W = frgcd_pkg::DATA_WIDTH_DEF;
  // generous run bound: every item at its longest euclid chain plus stalls, several times over
  localparam longint CYCLE_LIMIT = 10_000_000;
  // longest single item: about 48 remainder steps through the divider, rounded up
  localparam int SETTLE_CYCLES = 2000;

  // one expected result item
  typedef struct packed {
    logic signed [W-1:0] numer;
    logic signed [W-1:0] denom;
    logic signed [W-1:0] divisor;
    logic                fault;
  } reduced_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [W-1:0] numerator_in = '0;
  logic signed [W-1:0] denominator_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [W-1:0] numerator_out;
  logic signed [W-1:0] denominator_out;
  logic signed [W-1:0] common_divisor;
  logic                error_flag;

  // percent of cycles in which the sender holds back / the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  reduced_t    pending_results[$];
  int unsigned mismatch_count = 0;
  longint      cycle_count = 0;

  fraction_reduce_gcd_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .numerator_in   (numerator_in),
    .denominator_in (denominator_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .numerator_out  (numerator_out),
    .denominator_out(denominator_out),
    .common_divisor (common_divisor),
    .error_flag     (error_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // euclid with truncating remainder, so the divisor keeps the sign rules of the
  // remainder; 64-bit arithmetic keeps every intermediate exact
  function automatic reduced_t reduce_fraction(input logic signed [W-1:0] num,
                                               input logic signed [W-1:0] den);
    longint   min_val;
    longint   num_l;
    longint   den_l;
    longint   x;
    longint   y;
    longint   r;
    bit       fault;
    reduced_t res;
    min_val = -(longint'(1) <<< (W - 1));
    num_l = num;
    den_l = den;
    x = num_l;
    y = den_l;
    fault = 1'b0;
    while (y != 0 && !fault) begin
      // most negative value rem -1 overflows in W bits
      if (x == min_val && y == -1) begin
        fault = 1'b1;
      end else begin
        r = x % y;
        x = y;
        y = r;
      end
    end
    // both inputs zero leaves a zero divisor
    if (!fault && x == 0) fault = 1'b1;
    // most negative value divided by -1 overflows the quotient
    if (!fault && x == -1 && (num_l == min_val || den_l == min_val)) fault = 1'b1;
    if (fault) begin
      res.numer   = num;
      res.denom   = den;
      res.divisor = '0;
      res.fault   = 1'b1;
    end else begin
      res.numer   = W'(num_l / x);
      res.denom   = W'(den_l / x);
      res.divisor = W'(x);
      res.fault   = 1'b0;
    end
    return res;
  endfunction

  // receiver side: random stall, one assignment per edge
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped at cycle limit, %0d results outstanding",
               $time, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // both channels sampled at the edge: predict accepted items, check accepted results
  always @(posedge clk) begin
    reduced_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(reduce_fraction(numerator_in, denominator_in));
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none,",
                   $time,
                   " actual %0d/%0d gcd %0d err %0b",
                   numerator_out, denominator_out, common_divisor, error_flag);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (numerator_out !== want.numer) begin
            $display("%0t: numerator_out expected %0d actual %0d",
                     $time, want.numer, numerator_out);
            mismatch_count++;
          end
          if (denominator_out !== want.denom) begin
            $display("%0t: denominator_out expected %0d actual %0d",
                     $time, want.denom, denominator_out);
            mismatch_count++;
          end
          if (common_divisor !== want.divisor) begin
            $display("%0t: common_divisor expected %0d actual %0d",
                     $time, want.divisor, common_divisor);
            mismatch_count++;
          end
          if (error_flag !== want.fault) begin
            $display("%0t: error_flag expected %0b actual %0b",
                     $time, want.fault, error_flag);
            mismatch_count++;
          end
        end
      end
    end
  end

  // offer one item and hold it until the block takes it; valid stays high on return
  task automatic send_fraction(input logic signed [W-1:0] num,
                               input logic signed [W-1:0] den);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    numerator_in   <= num;
    denominator_in <= den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // extremes, both-zero, both overflow paths, signs and a long euclid chain
  task automatic test_corner_fractions();
    logic signed [W-1:0] min_v;
    logic signed [W-1:0] max_v;
    min_v = {1'b1, {(W-1){1'b0}}};
    max_v = {1'b0, {(W-1){1'b1}}};
    send_fraction(0, 0);            // zero divisor
    send_fraction(0, 5);
    send_fraction(5, 0);
    send_fraction(0, -5);
    send_fraction(min_v, -1);       // remainder overflow right away
    send_fraction(-1, min_v);       // remainder overflow after one step
    send_fraction(min_v, max_v);    // chain ends on -1 with min in the inputs
    send_fraction(max_v, min_v);
    send_fraction(min_v, min_v);
    send_fraction(min_v, 1);
    send_fraction(1, min_v);
    send_fraction(min_v, 0);
    send_fraction(0, min_v);
    send_fraction(min_v, -2);
    send_fraction(-2, min_v);
    send_fraction(max_v, max_v);
    send_fraction(max_v, 1);
    send_fraction(-1, -1);
    send_fraction(6, -4);           // remainder signs make the divisor positive here
    send_fraction(-6, 4);
    send_fraction(-6, -4);
    send_fraction(12, 18);
    send_fraction(1836311903, 1134903170);   // consecutive fibonacci, longest chain
    send_fraction(-1836311903, 1134903170);
  endtask

  // full-width random pairs, with some small values so zeros and units come up
  task automatic test_random_fractions(input int count);
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        num = int'($urandom_range(200)) - 100;
        den = int'($urandom_range(200)) - 100;
      end else begin
        num = $urandom;
        den = $urandom;
      end
      send_fraction(num, den);
    end
  endtask

  // pairs built with a known shared factor, signs at random
  task automatic test_scaled_fractions(input int count);
    longint factor;
    longint a;
    longint b;
    repeat (count) begin
      factor = ($urandom_range(3) == 0) ? longint'($urandom) : longint'($urandom_range(1, 4096));
      a = longint'($urandom_range(2000));
      b = longint'($urandom_range(2000));
      if ($urandom_range(1)) a = -a;
      if ($urandom_range(1)) b = -b;
      send_fraction(W'(a * factor), W'(b * factor));
    end
  endtask

  function automatic logic signed [W-1:0] edge_operand();
    logic signed [W-1:0] v;
    case ($urandom_range(7))
      0: v = {1'b1, {(W-1){1'b0}}};
      1: v = {1'b0, {(W-1){1'b1}}};
      2: v = 0;
      3: v = 1;
      4: v = -1;
      5: v = {1'b1, {(W-2){1'b0}}, 1'b1};
      6: v = 1 <<< $urandom_range(W - 2);
      default: v = -(1 <<< $urandom_range(W - 2));
    endcase
    return v;
  endfunction

  // range edges against each other and against random partners
  task automatic test_edge_fractions(input int count);
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    repeat (count) begin
      num = edge_operand();
      den = $urandom_range(1) ? edge_operand() : W'($urandom);
      if ($urandom_range(1)) send_fraction(num, den);
      else send_fraction(den, num);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls often
    send_idle_pct  = 25;
    recv_stall_pct = 64;
    test_corner_fractions();
    wait_results_drained();
    test_random_fractions(200);
    test_scaled_fractions(200);
    test_edge_fractions(117);
    wait_results_drained();

    // receiver stalls lightly, sender idles more
    send_idle_pct  = 64;
    recv_stall_pct = 25;
    test_random_fractions(200);
    test_scaled_fractions(200);
    test_edge_fractions(117);
    wait_results_drained();

    // back to back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_scaled_fractions(200);
    test_edge_fractions(117);
    test_random_fractions(200);
    wait_results_drained();

    // let any late result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
